@@ hdl/fat12_cluster_table_engine_top_macros.svh @@
// ---------------------------------------------------------------------------
// FAT12 cluster table engine - assertion macros
// Concurrent assertion wrappers clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_TABLE_ENGINE_TOP_MACROS_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FAT12_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FAT12_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define FAT12_ASSERT(lbl, prop, msg)
`define FAT12_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/fat12_pkg.sv @@
// ---------------------------------------------------------------------------
// FAT12 cluster table package
// Widths, codes, types and constants shared by the table engine.
// ---------------------------------------------------------------------------
package fat12_pkg;

   localparam int MAX_CLUSTERS = 4096;
   localparam int TABLE_DEPTH  = (MAX_CLUSTERS * 3) / 2;
   localparam int ROWS         = MAX_CLUSTERS / 2;
   localparam int ROW_W        = $clog2(ROWS);

   localparam int OPCODE_W   = 3;
   localparam int CLUSTER_W  = 12;
   localparam int ENTRY_W    = 12;
   localparam int ADDR_W     = 13;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int LBA_W      = 20;
   localparam int DSL_W      = 16;
   localparam int SPC_W      = 8;
   localparam int LIMIT_W    = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ROW_DATA_W = 2 * ENTRY_W;

   // floor(a/3) = (a * DIV3_MUL) >> DIV3_SHIFT, exact for any 13-bit a
   localparam int DIV3_W     = 16;
   localparam int DIV3_SHIFT = 17;
   localparam logic [DIV3_W-1:0] DIV3_MUL = 16'd43691;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;

   localparam logic [ENTRY_W-1:0] LAST_MARK = 12'hFFF;
   localparam logic [ENTRY_W-1:0] EOC_MARK  = 12'hFF8;
   localparam logic [LBA_W-1:0]   LBA_MAX   = 20'hFFFFF;

   localparam logic [DSL_W-1:0]   DSL_RESET   = 16'd33;
   localparam logic [SPC_W-1:0]   SPC_RESET   = 8'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2849;

   localparam logic [OPCODE_W-1:0] OPC_LOAD  = 3'd0;
   localparam logic [OPCODE_W-1:0] OPC_READ  = 3'd1;
   localparam logic [OPCODE_W-1:0] OPC_WRITE = 3'd2;
   localparam logic [OPCODE_W-1:0] OPC_ALLOC = 3'd3;
   localparam logic [OPCODE_W-1:0] OPC_CHAIN = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPC        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT      = 2'd2;

   typedef enum logic [2:0] {
      K_LOAD,
      K_READ,
      K_WRITE,
      K_ALLOC,
      K_CHAIN,
      K_NOP
   } fat12_kind_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_LINK_RD,
      S_LINK_WR,
      S_FINISH
   } fat12_state_type;

   typedef struct packed {
      logic [DSL_W-1:0]   dsl;
      logic [SPC_W-1:0]   spc;
      logic [LIMIT_W-1:0] limit;
   } fat12_cfg_type;

   typedef struct packed {
      fat12_kind_type     kind;
      logic               bad;
      logic               empty;
      logic [ROW_W-1:0]   row;
      logic [1:0]         bsel;
      logic               odd;
      logic [ENTRY_W-1:0] data;
      logic [CLUSTER_W-1:0] cluster;
      logic [LBA_W-1:0]   lba;
      logic [LIMIT_W-1:0] lim;
   } fat12_item_type;

   typedef struct packed {
      logic           valid;
      fat12_item_type item;
   } fat12_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } fat12_back_ctl_type;

endpackage

@@ hdl/fat12_if.sv @@
// ---------------------------------------------------------------------------
// FAT12 channel interfaces
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface fat12_req_if import fat12_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [CLUSTER_W-1:0] cluster;
   logic [ENTRY_W-1:0]   entry_data;
   logic [ADDR_W-1:0]    byte_address;
   logic [BYTE_W-1:0]    byte_data;

   modport source (output valid, opcode, cluster, entry_data, byte_address, byte_data,
                   input ready);
   modport sink (input valid, opcode, cluster, entry_data, byte_address, byte_data,
                 output ready);
endinterface

interface fat12_rsp_if import fat12_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRY_W-1:0]  entry_value;
   logic [LBA_W-1:0]    sector_lba;
   logic                end_of_chain;

   modport source (output valid, status, entry_value, sector_lba, end_of_chain,
                   input ready);
   modport sink (input valid, status, entry_value, sector_lba, end_of_chain,
                 output ready);
endinterface

@@ hdl/fat12_front.sv @@
// ---------------------------------------------------------------------------
// FAT12 front end
// Accepts requests, decodes and range-checks them, and queues them.
// ---------------------------------------------------------------------------
module fat12_front import fat12_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   fat12_req_if.sink          req,
   input  fat12_cfg_type      cfg,
   input  fat12_back_ctl_type ctl,
   output fat12_head_type     head
);

   localparam logic [LIMIT_W-1:0] CL_RANGE  = LIMIT_W'(MAX_CLUSTERS);
   localparam logic [ADDR_W-1:0]  ADDR_END  = ADDR_W'(TABLE_DEPTH);
   localparam logic [LIMIT_W-1:0] LIM_MIN   = 13'd3;
   localparam logic [Q_PTR_W:0]   Q_FULL    = (Q_PTR_W+1)'(Q_DEPTH);

   logic [ADDR_W+DIV3_W-1:0] quot_prod;
   logic [ROW_W-1:0]         load_row;
   logic [ADDR_W-1:0]        three_row;
   logic [ADDR_W-1:0]        load_rem;
   logic [CLUSTER_W-1:0]     c_m2;
   logic [LBA_W-1:0]         lba_prod;
   logic [LBA_W:0]           lba_sum;
   logic [LIMIT_W-1:0]       lim_eff;
   logic                     cl_bad;
   fat12_item_type           item;

   fat12_item_type           q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]         count_ff, count_in;
   logic                     push;

   // byte address to row of two entries and byte within that row
   assign quot_prod = {{DIV3_W{1'b0}}, req.byte_address} * {{ADDR_W{1'b0}}, DIV3_MUL};
   assign load_row  = quot_prod[DIV3_SHIFT +: ROW_W];
   assign three_row = ADDR_W'({load_row, 1'b0}) + ADDR_W'(load_row);
   assign load_rem  = req.byte_address - three_row;

   // first sector of the cluster, saturated
   assign c_m2     = req.cluster - CLUSTER_W'(2);
   assign lba_prod = LBA_W'({{SPC_W{1'b0}}, c_m2} * {{CLUSTER_W{1'b0}}, cfg.spc});
   assign lba_sum  = (LBA_W+1)'(lba_prod) + (LBA_W+1)'(cfg.dsl);

   assign lim_eff = (cfg.limit > CL_RANGE) ? CL_RANGE : cfg.limit;
   assign cl_bad  = LIMIT_W'(req.cluster) >= CL_RANGE;

   always_comb begin
      item         = '0;
      item.kind    = K_NOP;
      item.row     = req.cluster[1 +: ROW_W];
      item.odd     = req.cluster[0];
      item.bsel    = load_rem[1:0];
      item.cluster = req.cluster;
      item.lba     = lba_sum[LBA_W] ? LBA_MAX : lba_sum[LBA_W-1:0];
      item.lim     = lim_eff;
      case (req.opcode)
         OPC_LOAD: begin
            item.kind = K_LOAD;
            item.bad  = req.byte_address >= ADDR_END;
            item.row  = load_row;
            item.data = ENTRY_W'(req.byte_data);
         end
         OPC_READ: begin
            item.kind = K_READ;
            item.bad  = cl_bad;
         end
         OPC_WRITE: begin
            item.kind = K_WRITE;
            item.bad  = cl_bad;
            item.data = req.entry_data;
         end
         OPC_ALLOC: begin
            item.kind  = K_ALLOC;
            item.bad   = cl_bad;
            item.empty = lim_eff < LIM_MIN;
         end
         OPC_CHAIN: begin
            item.kind = K_CHAIN;
            item.bad  = cl_bad || (req.cluster < CLUSTER_W'(2));
         end
         default: begin
            item.kind = K_NOP;
         end
      endcase
   end

   // short queue toward the back end; hold off while the table is cleared
   assign req.ready = (count_ff != Q_FULL) && !ctl.clearing;
   assign push      = req.valid && req.ready;

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = ctl.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

@@ hdl/fat12_back.sv @@
// ---------------------------------------------------------------------------
// FAT12 back end
// Owns the packed table and executes queued requests against it.
// ---------------------------------------------------------------------------
`include "fat12_cluster_table_engine_top_macros.svh"

module fat12_back import fat12_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  fat12_head_type     head,
   output fat12_back_ctl_type ctl,
   fat12_rsp_if.source        rsp
);

   // row r holds entries 2r (bits 11:0) and 2r+1 (bits 23:12), i.e. bytes 3r..3r+2
   logic [ROW_DATA_W-1:0] mem [ROWS];
   logic [ROW_DATA_W-1:0] rd_data_ff;
   logic [ROW_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [ROW_W-1:0]      mem_wa;
   logic [ROW_DATA_W-1:0] mem_wd;

   fat12_state_type       state_ff, state_in;
   fat12_item_type        cur_ff, cur_in;
   logic [ROW_W-1:0]      clr_ff, clr_in;
   logic [ROW_W-1:0]      chk_ff, chk_in;
   logic [STATUS_W-1:0]   fin_status_ff, fin_status_in;
   logic [ENTRY_W-1:0]    fin_value_ff, fin_value_in;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ENTRY_W-1:0]    rsp_value_ff;
   logic [LBA_W-1:0]      rsp_lba_ff;
   logic                  rsp_eoc_ff;

   logic                  out_free;
   logic                  emit;
   logic [STATUS_W-1:0]   em_status;
   logic [ENTRY_W-1:0]    em_value;
   logic [LBA_W-1:0]      em_lba;
   logic                  em_eoc;

   logic [ENTRY_W-1:0]    ev, od, cur_entry;
   logic [LIMIT_W-1:0]    chk2;
   logic                  hit_ev, hit_od, more, do_link;
   logic [ENTRY_W-1:0]    k;

   function automatic logic [ROW_DATA_W-1:0] put_entry(input logic [ROW_DATA_W-1:0] row,
                                                        input logic odd,
                                                        input logic [ENTRY_W-1:0] v);
      logic [ROW_DATA_W-1:0] r;
      r = odd ? {v, row[ENTRY_W-1:0]} : {row[ROW_DATA_W-1:ENTRY_W], v};
      return r;
   endfunction

   function automatic logic [ROW_DATA_W-1:0] put_byte(input logic [ROW_DATA_W-1:0] row,
                                                       input logic [1:0] sel,
                                                       input logic [BYTE_W-1:0] b);
      logic [ROW_DATA_W-1:0] r;
      case (sel)
         2'd0:    r = {row[23:8], b};
         2'd1:    r = {row[23:16], b, row[7:0]};
         default: r = {b, row[15:0]};
      endcase
      return r;
   endfunction

   assign ev        = rd_data_ff[ENTRY_W-1:0];
   assign od        = rd_data_ff[ROW_DATA_W-1:ENTRY_W];
   assign cur_entry = cur_ff.odd ? od : ev;

   // free-entry check on the row read back during the search
   assign chk2    = LIMIT_W'({chk_ff, 1'b0});
   assign hit_ev  = (ev == '0) && (chk2 < cur_ff.lim);
   assign hit_od  = (od == '0) && ((chk2 + LIMIT_W'(1)) < cur_ff.lim);
   assign more    = (chk2 + LIMIT_W'(2)) < cur_ff.lim;
   assign k       = ENTRY_W'({chk_ff, !hit_ev});
   assign do_link = (cur_ff.cluster != '0) && (cur_ff.cluster != k);

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      clr_in        = clr_ff;
      chk_in        = chk_ff;
      fin_status_in = fin_status_ff;
      fin_value_in  = fin_value_ff;
      rd_addr       = cur_ff.row;
      mem_we        = 1'b0;
      mem_wa        = cur_ff.row;
      mem_wd        = rd_data_ff;
      ctl.pop       = 1'b0;
      ctl.clearing  = 1'b0;
      emit          = 1'b0;
      em_status     = STS_OK;
      em_value      = '0;
      em_lba        = '0;
      em_eoc        = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctl.clearing = 1'b1;
            mem_we       = 1'b1;
            mem_wa       = clr_ff;
            mem_wd       = '0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = head.item.row;
            if (head.valid) begin
               ctl.pop = 1'b1;
               cur_in  = head.item;
               if (head.item.kind == K_ALLOC && !head.item.bad && !head.item.empty) begin
                  rd_addr  = ROW_W'(1);
                  chk_in   = ROW_W'(1);
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (cur_ff.bad) begin
                  em_status = STS_RANGE;
               end else begin
                  case (cur_ff.kind)
                     K_LOAD: begin
                        mem_we = 1'b1;
                        mem_wd = put_byte(rd_data_ff, cur_ff.bsel, cur_ff.data[BYTE_W-1:0]);
                     end
                     K_READ: begin
                        em_value = cur_entry;
                     end
                     K_WRITE: begin
                        mem_we   = 1'b1;
                        mem_wd   = put_entry(rd_data_ff, cur_ff.odd, cur_ff.data);
                        em_value = cur_ff.data;
                     end
                     K_ALLOC: begin
                        em_status = STS_NO_SPACE;
                     end
                     K_CHAIN: begin
                        em_value = cur_entry;
                        em_lba   = cur_ff.lba;
                        em_eoc   = cur_entry >= EOC_MARK;
                     end
                     default: begin
                        em_status = STS_OK;
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            rd_addr = chk_ff + 1'b1;
            if (hit_ev || hit_od) begin
               mem_we        = 1'b1;
               mem_wa        = chk_ff;
               mem_wd        = put_entry(rd_data_ff, !hit_ev, LAST_MARK);
               fin_status_in = STS_OK;
               fin_value_in  = k;
               state_in      = do_link ? S_LINK_RD : S_FINISH;
            end else if (more) begin
               chk_in = chk_ff + 1'b1;
            end else begin
               fin_status_in = STS_NO_SPACE;
               fin_value_in  = '0;
               state_in      = S_FINISH;
            end
         end
         S_LINK_RD: begin
            state_in = S_LINK_WR;
         end
         S_LINK_WR: begin
            mem_we   = 1'b1;
            mem_wd   = put_entry(rd_data_ff, cur_ff.odd, fin_value_ff);
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               emit      = 1'b1;
               em_status = fin_status_ff;
               em_value  = fin_value_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      chk_ff        <= chk_in;
      fin_status_ff <= fin_status_in;
      fin_value_ff  <= fin_value_in;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= em_status;
         rsp_value_ff  <= em_value;
         rsp_lba_ff    <= em_lba;
         rsp_eoc_ff    <= em_eoc;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.entry_value  = rsp_value_ff;
   assign rsp.sector_lba   = rsp_lba_ff;
   assign rsp.end_of_chain = rsp_eoc_ff;

   `FAT12_ASSERT(a_clear_no_pop, (state_ff == S_CLEAR) |-> !ctl.pop, "pop during table clear")
   `FAT12_ASSERT(a_idle_no_write, (state_ff == S_IDLE) |-> !mem_we, "table write while idle")
   `FAT12_ASSERT(a_scan_bound, (state_ff == S_SCAN) |-> (chk2 < cur_ff.lim), "search past limit")
   `FAT12_ASSERT_NEXT(a_emit_loads, emit, rsp_valid_ff, "result register not loaded")

endmodule

@@ hdl/fat12_cluster_table_engine_top.sv @@
// ---------------------------------------------------------------------------
// FAT12 cluster table engine - top level
// Packed 12-bit allocation table with load, read, write, allocate and
// chain-next requests, plus a small register block for geometry.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake        payload
//   req_ch   in         valid/ready      opcode, cluster, entry_data,
//                                        byte_address, byte_data
//   rsp_ch   out        valid/ready      status, entry_value, sector_lba,
//                                        end_of_chain
//   csr_*    in         csr_we only      csr_index, csr_wdata
//
// Load, read, write, chain-next and rejected requests each go through one
// table row read in the back end, then the write-back and the result.
// Allocate searches rows instead, two entries per row, one row per cycle
// on the single read port; when a link is written, the previous cluster's
// row is then read and written back. After reset a clearing pass zeroes
// all 2048 rows of the table, one row per cycle; requests are held off
// meanwhile, register writes are taken. A stalled response holds in the
// output register; the two-deep front queue keeps accepting until it fills.
// ---------------------------------------------------------------------------
module fat12_cluster_table_engine_top import fat12_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fat12_req_if.sink             req_ch,
   fat12_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   fat12_cfg_type      cfg_ff, cfg_in;
   fat12_head_type     head;
   fat12_back_ctl_type ctl;

   // register block: each register takes the low bits of the write data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DATA_START: cfg_in.dsl   = csr_wdata[DSL_W-1:0];
            CSR_SPC:        cfg_in.spc   = csr_wdata[SPC_W-1:0];
            CSR_LIMIT:      cfg_in.limit = csr_wdata[LIMIT_W-1:0];
            default:        cfg_in       = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dsl   <= DSL_RESET;
         cfg_ff.spc   <= SPC_RESET;
         cfg_ff.limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode, range-check and queue requests
   fat12_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .cfg   (cfg_ff),
      .ctl   (ctl),
      .head  (head)
   );

   // execute against the table and drive the response register
   fat12_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .ctl   (ctl),
      .rsp   (rsp_ch)
   );

endmodule

@@ verif/fat12_cluster_table_engine_checker.sv @@
// ---------------------------------------------------------------------------
// FAT12 cluster table engine - response checker
// Keeps its own copy of the packed table and geometry registers, works out
// the response of every accepted request and compares it with the engine.
// ---------------------------------------------------------------------------
module fat12_cluster_table_engine_checker import fat12_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fat12_req_if                  req_mon,
   fat12_rsp_if                  rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           failures,
   output int unsigned           outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  entry_value;
      logic [LBA_W-1:0]    sector_lba;
      logic                end_of_chain;
   } table_result_type;

   logic [BYTE_W-1:0]  fat_bytes [TABLE_DEPTH];
   logic [DSL_W-1:0]   data_start;
   logic [SPC_W-1:0]   cluster_sectors;
   logic [LIMIT_W-1:0] search_limit;
   table_result_type   expected_results [$];

   // entry n starts at byte n + n/2; odd entries start on the high nibble
   function automatic logic [ENTRY_W-1:0] entry_fetch(int idx);
      int          off;
      logic [15:0] pair;
      off  = idx + idx / 2;
      pair = {fat_bytes[off + 1], fat_bytes[off]};
      if (idx % 2 == 0) begin
         return pair[11:0];
      end
      return pair[15:4];
   endfunction

   function automatic void entry_store(int idx, logic [ENTRY_W-1:0] value);
      int off;
      off = idx + idx / 2;
      if (idx % 2 == 0) begin
         fat_bytes[off]     = value[7:0];
         fat_bytes[off + 1] = {fat_bytes[off + 1][7:4], value[11:8]};
      end else begin
         fat_bytes[off]     = {value[3:0], fat_bytes[off][3:0]};
         fat_bytes[off + 1] = value[11:4];
      end
   endfunction

   function automatic table_result_type execute_request(
      logic [OPCODE_W-1:0]  opcode,
      logic [CLUSTER_W-1:0] cluster,
      logic [ENTRY_W-1:0]   entry_data,
      logic [ADDR_W-1:0]    byte_address,
      logic [BYTE_W-1:0]    byte_data
   );
      table_result_type res;
      int               lim;
      int               found;
      int               full;
      res = '0;
      case (opcode)
         OPC_LOAD: begin
            if (int'(byte_address) < TABLE_DEPTH) begin
               fat_bytes[byte_address] = byte_data;
            end else begin
               res.status = STS_RANGE;
            end
         end
         OPC_READ: begin
            if (int'(cluster) < MAX_CLUSTERS) begin
               res.entry_value = entry_fetch(cluster);
            end else begin
               res.status = STS_RANGE;
            end
         end
         OPC_WRITE: begin
            if (int'(cluster) < MAX_CLUSTERS) begin
               entry_store(cluster, entry_data);
               res.entry_value = entry_data;
            end else begin
               res.status = STS_RANGE;
            end
         end
         OPC_ALLOC: begin
            if (int'(cluster) >= MAX_CLUSTERS) begin
               res.status = STS_RANGE;
            end else begin
               lim   = (int'(search_limit) > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(search_limit);
               found = -1;
               for (int k = 2; k < lim && found < 0; k++) begin
                  if (entry_fetch(k) == '0) found = k;
               end
               if (found < 0) begin
                  res.status = STS_NO_SPACE;
               end else begin
                  entry_store(found, LAST_MARK);
                  // a previous cluster equal to the new one is only marked
                  if (cluster != '0 && int'(cluster) != found) begin
                     entry_store(cluster, ENTRY_W'(found));
                  end
                  res.entry_value = ENTRY_W'(found);
               end
            end
         end
         OPC_CHAIN: begin
            if (cluster < 2 || int'(cluster) >= MAX_CLUSTERS) begin
               res.status = STS_RANGE;
            end else begin
               full = int'(data_start) + (int'(cluster) - 2) * int'(cluster_sectors);
               res.sector_lba   = (full > int'(LBA_MAX)) ? LBA_MAX : LBA_W'(full);
               res.entry_value  = entry_fetch(cluster);
               res.end_of_chain = (res.entry_value >= EOC_MARK);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : watch
      table_result_type want;
      if (reset) begin
         foreach (fat_bytes[i]) fat_bytes[i] = '0;
         data_start      = DSL_RESET;
         cluster_sectors = SPC_RESET;
         search_limit    = LIMIT_RESET;
         expected_results.delete();
         failures = 0;
      end else begin
         // retire the response first: it always belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: status %0h, entry_value %0h",
                      rsp_mon.status, rsp_mon.entry_value);
               failures++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", want.status, rsp_mon.status);
               compare_field("entry_value", want.entry_value, rsp_mon.entry_value);
               compare_field("sector_lba", want.sector_lba, rsp_mon.sector_lba);
               compare_field("end_of_chain", want.end_of_chain, rsp_mon.end_of_chain);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DATA_START: data_start      = csr_wdata[DSL_W-1:0];
               CSR_SPC:        cluster_sectors = csr_wdata[SPC_W-1:0];
               CSR_LIMIT:      search_limit    = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(execute_request(req_mon.opcode, req_mon.cluster,
               req_mon.entry_data, req_mon.byte_address, req_mon.byte_data));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

@@ verif/fat12_cluster_table_engine_top_tb.sv @@
// ---------------------------------------------------------------------------
// FAT12 cluster table engine - testbench top
// Resets the engine once, runs a directed pass over the table edges and
// special cases, then several random phases under different geometry
// settings, with bursty requests and a stalling response side.
// ---------------------------------------------------------------------------
module fat12_cluster_table_engine_top_tb;
   import fat12_pkg::*;

   // Generous ceiling: the clearing pass plus every request as a full-table
   // allocation with the longest response stall, taken several times over.
   localparam int unsigned CYCLE_LIMIT   = 12_000_000;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          PHASE_COUNT   = 6;
   localparam int          PHASE_ITEMS   = 285;

   // spare opcodes, which the engine answers as no-ops with an OK status
   localparam logic [OPCODE_W-1:0] OPC_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OPC_SPARE_LAST  = 3'd7;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_HOLD,
      RX_TOGGLE
   } rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           failures;
   int unsigned           outstanding;
   int unsigned           cycle_count;
   int                    burst_left;
   int                    rx_left;
   int                    win_hi;
   rx_mode_type           rx_mode;

   fat12_req_if req_ch ();
   fat12_rsp_if rsp_ch ();

   fat12_cluster_table_engine_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fat12_cluster_table_engine_checker mirror (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Response side: switch between open, coin-flip, solid hold and toggle
   // patterns so that stalls land on every phase of the engine's work.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(3));
         rx_left = (rx_mode == RX_HOLD) ? $urandom_range(12, 1) : $urandom_range(60, 5);
      end else begin
         rx_left = rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN: rsp_ch.ready <= 1'b1;
         RX_COIN: rsp_ch.ready <= 1'($urandom_range(1));
         RX_HOLD: rsp_ch.ready <= 1'b0;
         default: rsp_ch.ready <= ~rsp_ch.ready;
      endcase
   end

   // Drive one request at the falling edge and hold it until the engine
   // takes it. Between bursts, drop valid for a random gap (sometimes none).
   task automatic send_request(
      input logic [OPCODE_W-1:0]  opcode,
      input logic [CLUSTER_W-1:0] cluster,
      input logic [ENTRY_W-1:0]   entry_data,
      input logic [ADDR_W-1:0]    byte_address,
      input logic [BYTE_W-1:0]    byte_data
   );
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(24, 1);
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= opcode;
      req_ch.cluster      <= cluster;
      req_ch.entry_data   <= entry_data;
      req_ch.byte_address <= byte_address;
      req_ch.byte_data    <= byte_data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   // Hold off new requests until every pending response is back, then let
   // the back end settle before anything touches the registers.
   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Write all three geometry registers; fill the unused upper bits with
   // noise so the engine is seen to ignore them.
   task automatic program_geometry(input logic [DSL_W-1:0]   dsl,
                                   input logic [SPC_W-1:0]   spc,
                                   input logic [LIMIT_W-1:0] limit);
      write_register(CSR_DATA_START, dsl);
      write_register(CSR_SPC, {8'($urandom), spc});
      write_register(CSR_LIMIT, {3'($urandom), limit});
   endtask

   // Random request: mostly clusters and bytes inside a small window near
   // the start of the table, so allocations, links and chain walks keep
   // meeting each other; the rest roams the full field ranges.
   task automatic random_request(input int hi);
      int                   pick;
      logic [OPCODE_W-1:0]  op;
      logic [CLUSTER_W-1:0] cl;
      logic [ENTRY_W-1:0]   data;
      logic [ADDR_W-1:0]    addr;
      pick = $urandom_range(99);
      if (pick < 12)      op = OPC_LOAD;
      else if (pick < 30) op = OPC_READ;
      else if (pick < 50) op = OPC_WRITE;
      else if (pick < 70) op = OPC_ALLOC;
      else if (pick < 95) op = OPC_CHAIN;
      else                op = OPCODE_W'($urandom_range(OPC_SPARE_LAST, OPC_SPARE_FIRST));

      cl = ($urandom_range(4) == 0) ? CLUSTER_W'($urandom) : CLUSTER_W'($urandom_range(hi));
      if (op == OPC_ALLOC && $urandom_range(2) == 0) cl = '0;

      // free marks, end-of-chain marks and in-window links dominate writes
      pick = $urandom_range(99);
      if (pick < 30)      data = '0;
      else if (pick < 45) data = ENTRY_W'($urandom_range(LAST_MARK, EOC_MARK));
      else if (pick < 80) data = ENTRY_W'($urandom_range(hi, 2));
      else                data = ENTRY_W'($urandom);

      pick = $urandom_range(99);
      if (pick < 75)      addr = ADDR_W'($urandom_range(hi + hi / 2 + 1));
      else if (pick < 90) addr = ADDR_W'($urandom_range(TABLE_DEPTH - 1));
      else                addr = ADDR_W'($urandom);

      send_request(op, cl, data, addr, BYTE_W'($urandom));
   endtask

   // Run ceiling.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("fat12_cluster_table_engine_top_tb: errors");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = '0;
      req_ch.cluster      = '0;
      req_ch.entry_data   = '0;
      req_ch.byte_address = '0;
      req_ch.byte_data    = '0;
      rsp_ch.ready        = 1'b0;
      burst_left          = 0;
      rx_left             = 0;
      rx_mode             = RX_OPEN;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed pass, reset geometry in force ------------------------
      // The engine clears its table first; send_request simply waits.
      send_request(OPC_READ, 12'd0, 12'h000, 13'd0, 8'h00);
      // build entries 2 and 3 from raw bytes (even and odd alignment)
      send_request(OPC_LOAD, 12'd0, 12'h000, 13'd3, 8'hAB);
      send_request(OPC_LOAD, 12'd0, 12'h000, 13'd4, 8'hCD);
      send_request(OPC_LOAD, 12'd0, 12'h000, 13'd5, 8'hEF);
      // last byte of the table, then loads just past it and at the top
      send_request(OPC_LOAD, 12'd0, 12'h000, 13'd6143, 8'hFF);
      send_request(OPC_LOAD, 12'd0, 12'h000, 13'd6144, 8'h5A);
      send_request(OPC_LOAD, 12'd0, 12'h000, 13'd8191, 8'hA5);
      send_request(OPC_READ, 12'd2, 12'h000, 13'd0, 8'h00);
      send_request(OPC_READ, 12'd3, 12'h000, 13'd0, 8'h00);
      send_request(OPC_READ, 12'd4095, 12'h000, 13'd0, 8'h00);
      send_request(OPC_WRITE, 12'd4094, 12'h000, 13'd0, 8'h00);
      send_request(OPC_WRITE, 12'd4095, 12'hFFF, 13'd0, 8'h00);
      // one entry just below the end-of-chain mark, one right on it
      send_request(OPC_WRITE, 12'd4, 12'hFF7, 13'd0, 8'h00);
      send_request(OPC_WRITE, 12'd5, 12'hFF8, 13'd0, 8'h00);
      // clusters 0 and 1 have no data sectors
      send_request(OPC_CHAIN, 12'd0, 12'h000, 13'd0, 8'h00);
      send_request(OPC_CHAIN, 12'd1, 12'h000, 13'd0, 8'h00);
      send_request(OPC_CHAIN, 12'd4, 12'h000, 13'd0, 8'h00);
      send_request(OPC_CHAIN, 12'd5, 12'h000, 13'd0, 8'h00);
      send_request(OPC_CHAIN, 12'd4095, 12'h000, 13'd0, 8'h00);
      for (int op = OPC_SPARE_FIRST; op <= OPC_SPARE_LAST; op++) begin
         send_request(OPCODE_W'(op), 12'd4, 12'h123, 13'd7, 8'h77);
      end
      // first free is 6; then a previous cluster that is itself the free
      // one; then a link written into the very last entry
      send_request(OPC_ALLOC, 12'd0, 12'h000, 13'd0, 8'h00);
      send_request(OPC_ALLOC, 12'd7, 12'h000, 13'd0, 8'h00);
      send_request(OPC_ALLOC, 12'd4095, 12'h000, 13'd0, 8'h00);

      // ---- directed geometry corners --------------------------------------
      // a limit of 3 searches only cluster 2, which is taken: no space
      wait_for_results();
      program_geometry(16'd33, 8'd1, 13'd3);
      send_request(OPC_ALLOC, 12'd0, 12'h000, 13'd0, 8'h00);
      // a limit below 3 searches nothing
      wait_for_results();
      program_geometry(16'd0, 8'd0, 13'd0);
      send_request(OPC_ALLOC, 12'd0, 12'h000, 13'd0, 8'h00);
      send_request(OPC_CHAIN, 12'd4095, 12'h000, 13'd0, 8'h00);
      // highest start and sector count: the address saturates; a limit
      // above the table size behaves as the table size
      wait_for_results();
      program_geometry(16'hFFFF, 8'hFF, 13'h1FFF);
      send_request(OPC_CHAIN, 12'd4095, 12'h000, 13'd0, 8'h00);
      send_request(OPC_CHAIN, 12'd2, 12'h000, 13'd0, 8'h00);
      send_request(OPC_ALLOC, 12'd9, 12'h000, 13'd0, 8'h00);

      // ---- random phases ---------------------------------------------------
      // Drain before each reprogram: this is also where the sender pauses
      // until every expected response is back.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_results();
         case (phase)
            0: program_geometry(16'd0, 8'd1, 13'd4096);
            1: program_geometry(16'hFFFF, 8'd128, 13'h1FFF);
            2: program_geometry(16'($urandom), 8'd0, 13'($urandom_range(2)));
            3: program_geometry(16'($urandom), 8'($urandom_range(128, 1)),
                                13'($urandom_range(80, 3)));
            4: program_geometry(16'($urandom), 8'($urandom), 13'd3);
            default: program_geometry(16'($urandom), 8'($urandom), 13'($urandom));
         endcase
         win_hi = $urandom_range(64, 8);
         repeat (PHASE_ITEMS) random_request(win_hi);
      end

      wait_for_results();
      if (failures == 0) begin
         $display("fat12_cluster_table_engine_top_tb: clean");
      end else begin
         $display("fat12_cluster_table_engine_top_tb: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/fat12_pkg.sv
hdl/fat12_if.sv
hdl/fat12_front.sv
hdl/fat12_back.sv
hdl/fat12_cluster_table_engine_top.sv
verif/fat12_cluster_table_engine_checker.sv
verif/fat12_cluster_table_engine_top_tb.sv
